[hw/rtl/chbd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the chunked HTTP body decoder.
// No dependencies; imported by every chbd module and the core top level.
package chbd_pkg;

    localparam int LEN_BITS = 32;

    // Parser phases
    localparam logic [2:0] PH_SKIP_WS   = 3'd0;
    localparam logic [2:0] PH_DIGITS    = 3'd1;
    localparam logic [2:0] PH_SKIP_LINE = 3'd2;
    localparam logic [2:0] PH_PAYLOAD   = 3'd3;
    localparam logic [2:0] PH_STOPPED   = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [1:0] kind;
    } chbd_result_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Returns {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        hex_decode = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            hex_decode = {1'b1, v[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
            hex_decode = {1'b1, v[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
            hex_decode = {1'b1, v[3:0]};
        end
    endfunction

endpackage

[hw/rtl/chbd_parser.sv]
`timescale 1ns / 1ps
// Byte-wide chunk parser: phase and length registers plus the per-byte decode.
// Depends on chbd_pkg.
module chbd_parser
    import chbd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         beat_valid,
    input  logic         advance,
    input  logic [7:0]   beat_data,
    input  logic         beat_start,
    output chbd_result_t result
);

    logic [2:0]          phase_reg, phase_next;
    // One counter serves as the length being built and then as the bytes left
    logic [LEN_BITS-1:0] len_reg, len_next;

    logic [2:0]          phase_cur;
    logic [LEN_BITS-1:0] len_cur;
    logic [4:0]          hex;
    logic                step;

    assign step = beat_valid && advance;
    assign hex  = hex_decode(beat_data);

    always_comb begin
        phase_cur = beat_start ? PH_SKIP_WS : phase_reg;
        len_cur   = beat_start ? '0 : len_reg;

        phase_next  = phase_cur;
        len_next    = len_cur;
        result      = '0;
        result.kind = KIND_PAYLOAD;

        case (phase_cur)
            PH_SKIP_WS: begin
                if (!is_space(beat_data)) begin
                    if (!hex[4]) begin
                        phase_next   = PH_STOPPED;
                        result.valid = 1'b1;
                        result.kind  = KIND_BAD;
                    end else begin
                        len_next   = {{(LEN_BITS-4){1'b0}}, hex[3:0]};
                        phase_next = PH_DIGITS;
                    end
                end
            end
            PH_DIGITS: begin
                if (hex[4]) begin
                    if (len_cur[LEN_BITS-1 -: 4] != 4'd0) begin
                        phase_next   = PH_STOPPED;
                        result.valid = 1'b1;
                        result.kind  = KIND_BAD;
                    end else begin
                        len_next = {len_cur[LEN_BITS-5:0], hex[3:0]};
                    end
                end else if (len_cur == '0) begin
                    phase_next   = PH_STOPPED;
                    result.valid = 1'b1;
                    result.kind  = KIND_END;
                end else begin
                    phase_next = (beat_data == CHAR_LF) ? PH_PAYLOAD : PH_SKIP_LINE;
                end
            end
            PH_SKIP_LINE: begin
                if (beat_data == CHAR_LF) begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                len_next     = len_cur - 1'b1;
                result.valid = 1'b1;
                result.data  = beat_data;
                result.kind  = KIND_PAYLOAD;
                if (len_cur == {{(LEN_BITS-1){1'b0}}, 1'b1}) begin
                    phase_next = PH_SKIP_WS;
                end
            end
            default: begin
                // stopped, and unused codes: ignore until a new message
            end
        endcase

        if (!beat_valid) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP_WS;
            len_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
        end
    end

    // A report of end or malformed body always stops the parser
    a_report_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.valid && result.kind != KIND_PAYLOAD |=> phase_reg == PH_STOPPED)
        else $error("report without stop");

    // Payload phase is only entered with bytes left to pass
    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> len_reg != '0)
        else $error("payload phase with zero count");

    // A stopped body yields nothing until a new message starts
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_valid && !beat_start && phase_reg == PH_STOPPED |-> !result.valid)
        else $error("result after stop");

endmodule

[hw/rtl/chbd_out_reg.sv]
`timescale 1ns / 1ps
// Result register of the decoder: holds one result beat for the master side.
// Depends on chbd_pkg.
module chbd_out_reg
    import chbd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  chbd_result_t result,
    output logic         free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic [1:0]   m_tuser
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic [1:0] kind_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? result.valid : (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            data_reg <= result.data;
            kind_reg <= result.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule

[hw/rtl/http_chunked_body_decoder_core.sv]
`timescale 1ns / 1ps
// Chunked HTTP body decoder core: input register, chunk parser, result register.
// Depends on chbd_pkg, chbd_parser and chbd_out_reg.
//
// Takes one raw body byte per cycle and delivers payload bytes, then one end-of-body
// or malformed-body report. Sustained rate is one byte per cycle. A byte's result
// reaches m_ by way of the input register, loaded when the byte is accepted, and then
// the result register. While a result waits with m_tready low, both registers hold and
// s_tready drops. The loop through the phase and chunk length registers sets that rate.
// Set s_tuser on the first byte of a new body to restart the parser; after a report,
// bytes are dropped until that happens. Lengths up to LEN_BITS (32) bits are taken.
module http_chunked_body_decoder_core
    import chbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] message_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser    // [1:0] out_kind
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_data_reg;
    logic         in_start_reg;
    logic         out_free;
    logic         advance;
    chbd_result_t result;

    // Stage moves whenever the result register can take a beat
    assign advance       = out_free;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    chbd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (in_valid_reg),
        .advance    (advance),
        .beat_data  (in_data_reg),
        .beat_start (in_start_reg),
        .result     (result)
    );

    chbd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for http_chunked_body_decoder_core: drives chunked bodies,
// predicts payload, end and malformed reports, and checks every m_ beat in order.
// Depends on chbd_pkg and the core RTL.
module testbench;
    import chbd_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_CYCLES = 10;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } decoded_beat_t;

    // Tracks the decoder's parse state and the beats it still owes on m_.
    class chunk_board;
        logic [2:0]          phase;
        logic [LEN_BITS-1:0] chunk_len;
        logic [LEN_BITS-1:0] bytes_left;
        decoded_beat_t       owed[$];
        int                  errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_SKIP_WS;
            chunk_len  = '0;
            bytes_left = '0;
        endfunction

        static function bit is_blank(input logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        static function bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
            logic [7:0] v;
            v = 8'h00;
            n = 4'h0;
            if (c >= "0" && c <= "9") begin
                v = c - "0";
            end else if (c >= "a" && c <= "f") begin
                v = c - "a" + 8'd10;
            end else if (c >= "A" && c <= "F") begin
                v = c - "A" + 8'd10;
            end else begin
                return 1'b0;
            end
            n = v[3:0];
            return 1'b1;
        endfunction

        function void owe(input logic [1:0] kind, input logic [7:0] data);
            decoded_beat_t b;
            b.data = data;
            b.kind = kind;
            owed.push_back(b);
        endfunction

        function void note_raw_byte(input logic [7:0] c, input logic start);
            logic [3:0] n;
            bit         hex;
            if (start)
                restart();
            hex = hex_nibble(c, n);
            case (phase)
                PH_SKIP_WS: begin
                    if (!is_blank(c)) begin
                        if (!hex) begin
                            phase = PH_STOPPED;
                            owe(KIND_BAD, 8'h00);
                        end else begin
                            chunk_len = LEN_BITS'(n);
                            phase = PH_DIGITS;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (hex) begin
                        // a digit that would shift bits out of the counter is malformed
                        if (chunk_len[LEN_BITS-1 -: 4] != 4'h0) begin
                            phase = PH_STOPPED;
                            owe(KIND_BAD, 8'h00);
                        end else begin
                            chunk_len = {chunk_len[LEN_BITS-5:0], n};
                        end
                    end else if (chunk_len == '0) begin
                        phase = PH_STOPPED;
                        owe(KIND_END, 8'h00);
                    end else begin
                        bytes_left = chunk_len;
                        phase = (c == CHAR_LF) ? PH_PAYLOAD : PH_SKIP_LINE;
                    end
                end
                PH_SKIP_LINE: begin
                    if (c == CHAR_LF)
                        phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        chunk_len = '0;
                        phase = PH_SKIP_WS;
                    end
                    owe(KIND_PAYLOAD, c);
                end
                default: ;
            endcase
        endfunction

        function void check_decoded(input logic [7:0] data, input logic [1:0] kind);
            decoded_beat_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got byte %02h kind %0d",
                         $time, data, kind);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (kind !== e.kind) begin
                $display("%0t: out_kind expected %0d, got %0d", $time, e.kind, kind);
                errors++;
            end
            if (data !== e.data) begin
                $display("%0t: out_byte expected %02h, got %02h", $time, e.data, data);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic [0:0] s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    chunk_board board = new();
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         sent_count = 0;
    int         cycles = 0;
    bit         start_flag = 1'b0;

    http_chunked_body_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_raw_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
                board.check_decoded(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** http_chunked_body_decoder_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [7:0] pick_blank(input int i);
        case (i)
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input int n, input bit upper);
        if (n < 10)
            return 8'("0" + n);
        return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    // Hold the beat until accepted; start_flag marks the first byte of a body.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start_flag;
        do @(posedge aclk); while (!s_tready);
        start_flag = 1'b0;
        sent_count++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    task automatic send_hex_len(input int unsigned v);
        int nd;
        nd = 1;
        repeat ($urandom_range(0, 2))
            send_byte("0");
        while ((v >> (4 * nd)) != 0)
            nd++;
        for (int d = nd - 1; d >= 0; d--)
            send_byte(hex_char((v >> (4 * d)) & 15, $urandom_range(0, 1)));
    endtask

    task automatic send_line_end();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            2: send_byte(CHAR_LF);
            3: begin
                // chunk extension: arbitrary bytes up to the line feed
                send_byte(";");
                repeat ($urandom_range(0, 4)) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
                    send_byte(c);
                end
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default: begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
        endcase
    endtask

    task automatic send_chunked_body();
        int         chunks;
        int         len;
        int         cut;
        int         ending;
        logic [7:0] c;
        logic [3:0] n;
        chunks = $urandom_range(1, 4);
        ending = $urandom_range(0, 9);
        start_flag = 1'b1;
        for (int k = 0; k < chunks; k++) begin
            repeat ($urandom_range(0, 2))
                send_byte(pick_blank($urandom_range(0, 5)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            send_hex_len(len);
            send_line_end();
            // a truncated body is cut inside its last chunk; the next body restarts
            cut = (ending == 2 && k == chunks - 1) ? $urandom_range(0, len - 1) : len;
            for (int j = 0; j < cut; j++)
                send_byte(8'($urandom_range(0, 255)));
            if (cut != len)
                return;
        end
        case (ending)
            0: begin
                do c = 8'($urandom_range(0, 255));
                while (chunk_board::is_blank(c) || chunk_board::hex_nibble(c, n));
                send_byte(c);
            end
            1: begin
                send_byte(hex_char($urandom_range(1, 15), $urandom_range(0, 1)));
                repeat (8)
                    send_byte(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end
            default: begin
                send_hex_len(0);
                send_line_end();
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
        endcase
        // trailing bytes after the report are dropped
        repeat ($urandom_range(0, 3))
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 29;
        recv_idle_pct = 86;

        // every blank before a length, leading zero, length ended by a bare line feed
        start_flag = 1'b1;
        for (int i = 0; i < 6; i++)
            send_byte(pick_blank(i));
        send_text("01");
        send_byte(CHAR_LF);
        send_byte(8'hFF);
        send_text("1;");
        send_byte(CHAR_LF);
        send_byte(8'h00);
        // zero length ends the body; the byte after it is dropped
        send_byte("0");
        send_byte(CHAR_CR);
        send_byte("Z");
        // bad first character of a length
        start_flag = 1'b1;
        send_byte("~");
        // widest length, then one digit too many
        start_flag = 1'b1;
        send_text("FFFFFFFF");
        send_byte("f");
        start_flag = 1'b1;
        send_byte(8'h00);

        while (sent_count < 560)
            send_chunked_body();
        s_tvalid <= 1'b0;
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 29;
        while (sent_count < 1100)
            send_chunked_body();
        s_tvalid <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_count < 1650)
            send_chunked_body();
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0)
            $display("** http_chunked_body_decoder_core: PASSED **");
        else
            $display("** http_chunked_body_decoder_core: FAILED **");
        $finish;
    end

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

endmodule

[http_chunked_body_decoder_core.f]
hw/rtl/chbd_pkg.sv
hw/rtl/chbd_parser.sv
hw/rtl/chbd_out_reg.sv
hw/rtl/http_chunked_body_decoder_core.sv
test/testbench.sv
